FILE: rtl/stt_pkg.sv
// Shared constants and character class functions for the source text tokenizer.
package stt_pkg;

  // token classes
  localparam logic [2:0] CLS_NEWLINE = 3'd0;
  localparam logic [2:0] CLS_SPACE   = 3'd1;
  localparam logic [2:0] CLS_CMARK   = 3'd2;
  localparam logic [2:0] CLS_ANGLE   = 3'd3;
  localparam logic [2:0] CLS_SEP     = 3'd4;
  localparam logic [2:0] CLS_WORD    = 3'd5;
  localparam logic [2:0] CLS_WHOLE   = 3'd6;
  localparam logic [2:0] CLS_NONE    = 3'd7;

  // escape phases
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_AFTER = 2'd1;
  localparam logic [1:0] ESC_HEX   = 2'd2;
  localparam logic [1:0] ESC_OCT   = 2'd3;

  // enclosing contexts
  localparam logic [1:0] CTX_OTHER   = 2'd0;
  localparam logic [1:0] CTX_COMMENT = 2'd1;
  localparam logic [1:0] CTX_FILE    = 2'd2;
  localparam logic [1:0] CTX_LITERAL = 2'd3;

  // escape digit budgets
  localparam logic [3:0] DIGITS_X   = 4'd2;
  localparam logic [3:0] DIGITS_U4  = 4'd4;
  localparam logic [3:0] DIGITS_U8  = 4'd8;
  localparam logic [3:0] DIGITS_OCT = 4'd2;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // ( ) [ ] , " ' \ ; { } :
  function automatic logic is_sep(input logic [7:0] c);
    return c inside {8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h22, 8'h27, 8'h5C,
                     8'h3B, 8'h7B, 8'h7D, 8'h3A};
  endfunction

  // / * !
  function automatic logic is_cmark(input logic [7:0] c);
    return c inside {8'h2F, 8'h2A, 8'h21};
  endfunction

  // < >
  function automatic logic is_angle(input logic [7:0] c);
    return c inside {8'h3C, 8'h3E};
  endfunction

endpackage

FILE: rtl/source_text_tokenizer.sv
// Source text tokenizer: marks token starts and classes, one byte per word.
//
// Takes one byte per cycle while the output is not stalled and returns one
// word per byte: whether a new token starts there and its class. An accepted
// byte sits in an input register, is judged against the open-token state
// (class, escape phase, escape digit budget, quote/backslash merge flag) and
// lands in the result register. Throughput is one byte per cycle while the
// output is not stalled; both stages hold under back-pressure. The
// split_literals register resets to 1; the user must write it through the
// cfg channel only while no byte is in flight, which the block does not enforce.
module source_text_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,        // split_literals
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] text_char
  input  logic [2:0] s_axis_tuser,    // [0] first_of_text, [2:1] context_req
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [0] starts_token, [7:1] zero
  output logic [2:0] m_axis_tuser     // [2:0] token_class
);

  logic       split_literals;
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_first;
  logic [1:0] in_ctx;
  logic       advance;

  logic [2:0] open_class, open_class_next;
  logic [1:0] esc_phase, esc_phase_next;
  logic [3:0] digits_left, digits_left_next;
  logic       merge_open, merge_open_next;
  logic       cont;
  logic       whole;
  logic       sep_cont;
  logic [2:0] start_cls;

  logic       out_starts;
  logic [2:0] out_class;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_literals <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      split_literals <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char  <= s_axis_tdata;
      in_first <= s_axis_tuser[0];
      in_ctx   <= s_axis_tuser[2:1];
    end
  end

  always_comb begin
    if (in_char == stt_pkg::CH_NL) begin
      start_cls = stt_pkg::CLS_NEWLINE;
    end else if (stt_pkg::is_space(in_char)) begin
      start_cls = stt_pkg::CLS_SPACE;
    end else if (in_ctx == stt_pkg::CTX_COMMENT && stt_pkg::is_cmark(in_char)) begin
      start_cls = stt_pkg::CLS_CMARK;
    end else if (in_ctx == stt_pkg::CTX_FILE && stt_pkg::is_angle(in_char)) begin
      start_cls = stt_pkg::CLS_ANGLE;
    end else if (stt_pkg::is_sep(in_char)) begin
      start_cls = stt_pkg::CLS_SEP;
    end else begin
      start_cls = stt_pkg::CLS_WORD;
    end
  end

  always_comb begin
    whole            = (in_ctx == stt_pkg::CTX_LITERAL) && !split_literals;
    sep_cont         = 1'b0;
    cont             = 1'b0;
    open_class_next  = open_class;
    esc_phase_next   = esc_phase;
    digits_left_next = digits_left;
    merge_open_next  = merge_open;

    // separator continuation: escape sequence, then quote/backslash merge
    if (esc_phase == stt_pkg::ESC_AFTER) begin
      sep_cont       = 1'b1;
      esc_phase_next = stt_pkg::ESC_HEX;
      if (in_char == stt_pkg::CH_X) begin
        digits_left_next = stt_pkg::DIGITS_X;
      end else if (in_char == stt_pkg::CH_U) begin
        digits_left_next = stt_pkg::DIGITS_U4;
      end else if (in_char == stt_pkg::CH_UU) begin
        digits_left_next = stt_pkg::DIGITS_U8;
      end else if (stt_pkg::is_dec(in_char)) begin
        esc_phase_next   = stt_pkg::ESC_OCT;
        digits_left_next = stt_pkg::DIGITS_OCT;
      end else begin
        esc_phase_next   = stt_pkg::ESC_NONE;
        digits_left_next = 4'd0;
      end
    end else begin
      if ((esc_phase == stt_pkg::ESC_HEX || esc_phase == stt_pkg::ESC_OCT) &&
          ((esc_phase == stt_pkg::ESC_HEX) ? stt_pkg::is_hex(in_char)
                                           : stt_pkg::is_oct(in_char)) &&
          digits_left != 4'd0) begin
        sep_cont         = 1'b1;
        digits_left_next = digits_left - 4'd1;
        if (digits_left == 4'd1) begin
          esc_phase_next = stt_pkg::ESC_NONE;
        end
      end else if (in_ctx == stt_pkg::CTX_LITERAL && merge_open &&
                   (in_char == stt_pkg::CH_QUOTE || in_char == stt_pkg::CH_BSLASH)) begin
        sep_cont         = 1'b1;
        merge_open_next  = 1'b1;
        esc_phase_next   = (in_char == stt_pkg::CH_BSLASH) ? stt_pkg::ESC_AFTER
                                                           : stt_pkg::ESC_NONE;
        digits_left_next = 4'd0;
      end
    end

    if (!in_first) begin
      if (whole) begin
        cont = (open_class == stt_pkg::CLS_WHOLE);
      end else begin
        case (open_class)
          stt_pkg::CLS_CMARK: cont = (in_ctx == stt_pkg::CTX_COMMENT) &&
                                     stt_pkg::is_cmark(in_char);
          stt_pkg::CLS_ANGLE: cont = (in_ctx == stt_pkg::CTX_FILE) &&
                                     stt_pkg::is_angle(in_char);
          stt_pkg::CLS_SEP:   cont = sep_cont;
          stt_pkg::CLS_WORD:  cont = !stt_pkg::is_space(in_char) &&
                                     !(in_ctx == stt_pkg::CTX_COMMENT &&
                                       stt_pkg::is_cmark(in_char)) &&
                                     !(in_ctx == stt_pkg::CTX_FILE &&
                                       stt_pkg::is_angle(in_char)) &&
                                     !stt_pkg::is_sep(in_char);
          default:            cont = 1'b0;
        endcase
      end
    end

    // escape state only moves while a separator token continues or a new token starts
    if (cont && !(open_class == stt_pkg::CLS_SEP && !whole)) begin
      esc_phase_next   = esc_phase;
      digits_left_next = digits_left;
      merge_open_next  = merge_open;
    end

    if (!cont) begin
      open_class_next  = whole ? stt_pkg::CLS_WHOLE : start_cls;
      esc_phase_next   = stt_pkg::ESC_NONE;
      digits_left_next = 4'd0;
      merge_open_next  = 1'b0;
      if (!whole && start_cls == stt_pkg::CLS_SEP) begin
        merge_open_next = (in_char == stt_pkg::CH_QUOTE) ||
                          (in_char == stt_pkg::CH_BSLASH);
        esc_phase_next  = (in_char == stt_pkg::CH_BSLASH) ? stt_pkg::ESC_AFTER
                                                          : stt_pkg::ESC_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_class  <= stt_pkg::CLS_NONE;
      esc_phase   <= stt_pkg::ESC_NONE;
      digits_left <= 4'd0;
      merge_open  <= 1'b0;
    end else if (advance) begin
      open_class  <= open_class_next;
      esc_phase   <= esc_phase_next;
      digits_left <= digits_left_next;
      merge_open  <= merge_open_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_starts <= !cont;
      out_class  <= open_class_next;
    end
  end

  assign m_axis_tdata = {7'd0, out_starts};
  assign m_axis_tuser = out_class;

  a_esc_in_sep: assert property (@(posedge clk) disable iff (rst)
    esc_phase != stt_pkg::ESC_NONE |-> open_class == stt_pkg::CLS_SEP)
    else $error("escape pending outside a separator token");

  a_merge_in_sep: assert property (@(posedge clk) disable iff (rst)
    merge_open |-> open_class == stt_pkg::CLS_SEP)
    else $error("merge flag set outside a separator token");

  a_digits_phase: assert property (@(posedge clk) disable iff (rst)
    digits_left != 4'd0 |-> (esc_phase == stt_pkg::ESC_HEX ||
                             esc_phase == stt_pkg::ESC_OCT) && digits_left <= 4'd8)
    else $error("escape digit budget out of step with escape phase");

  a_first_starts: assert property (@(posedge clk) disable iff (rst)
    advance && in_first |=> m_axis_tvalid && m_axis_tdata[0])
    else $error("first byte of a run did not start a token");

endmodule
